/* rtl/core/lspe_pkg.sv */
// Shared types and constants for the line stipple pattern expander.
// No dependencies; every other file in rtl/core takes names from here.
package lspe_pkg;

  localparam int WORD_BITS   = 32;
  localparam int WORD_LIMIT  = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam int BITS_W  = WORD_BITS;
  localparam int LEN_W   = 6;
  localparam int SCALE_W = 8;
  localparam int SLEN_W  = 13;
  localparam int IDX_W   = 6;
  localparam int COUNT_W = 7;
  localparam int TZ_W    = 4;
  localparam int POS_W   = $clog2(WORD_BITS);
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

  localparam logic [BITS_W-1:0]  SOLID_WORD  = '1;
  localparam logic [LEN_W-1:0]   LEN_MAX     = LEN_W'(WORD_BITS);
  localparam logic [COUNT_W-1:0] COUNT_CAP   = COUNT_W'(WORD_LIMIT);
  // word count search: 32 = 2**5, so five trailing zeros of slen come free
  localparam logic [TZ_W-1:0]    WORD_SHIFT  = TZ_W'($clog2(WORD_BITS));

  // classified request handed from the front to the back
  typedef struct packed {
    logic [BITS_W-1:0]  pattern_bits;
    logic [LEN_W-1:0]   len;
    logic [SCALE_W-1:0] scale;
    logic [SLEN_W-1:0]  slen;
    logic [COUNT_W-1:0] count;
    logic               solid;
  } lspe_job_t;

endpackage

/* rtl/core/lspe_req_if.sv */
// Request channel: valid/ready handshake plus the stipple request fields.
// Depends on lspe_pkg for field widths.
interface lspe_req_if;
  logic                            valid;
  logic                            ready;
  logic [lspe_pkg::BITS_W-1:0]     pattern_bits;
  logic [lspe_pkg::LEN_W-1:0]      pattern_length;
  logic [lspe_pkg::SCALE_W-1:0]    scale_factor;

  modport source (output valid, pattern_bits, pattern_length, scale_factor, input ready);
  modport sink   (input valid, pattern_bits, pattern_length, scale_factor, output ready);
endinterface

/* rtl/core/lspe_word_if.sv */
// Result channel: valid/ready handshake plus one expanded pattern word.
// Depends on lspe_pkg for field widths.
interface lspe_word_if;
  logic                            valid;
  logic                            ready;
  logic [lspe_pkg::BITS_W-1:0]     pattern_word;
  logic [lspe_pkg::IDX_W-1:0]      word_index;
  logic [lspe_pkg::COUNT_W-1:0]    word_count;
  logic [lspe_pkg::SLEN_W-1:0]     scaled_length;
  logic                            last_word;

  modport source (output valid, pattern_word, word_index, word_count, scaled_length,
                  last_word, input ready);
  modport sink   (input valid, pattern_word, word_index, word_count, scaled_length,
                  last_word, output ready);
endinterface

/* rtl/core/lspe_front.sv */
// Front end: accepts a request, saturates length/scale, computes the scaled
// length and the word count (trailing-zero search). Uses lspe_pkg, lspe_req_if.
module lspe_front (
  input  logic                clk,
  input  logic                rst,
  lspe_req_if.sink            req,
  output logic                job_valid,
  input  logic                job_ready,
  output lspe_pkg::lspe_job_t job
);

  typedef enum logic [1:0] {F_IDLE, F_SEARCH, F_PUSH} state_t;

  state_t                         state;
  logic [lspe_pkg::SLEN_W-1:0]    odd;
  logic [lspe_pkg::TZ_W-1:0]      tz;

  logic [lspe_pkg::LEN_W-1:0]     len_sat;
  logic [lspe_pkg::SCALE_W-1:0]   scale_eff;
  logic [lspe_pkg::SLEN_W-1:0]    slen_calc;
  logic [2:0]                     extra_shift;
  logic [19:0]                    cnt_raw;
  logic [lspe_pkg::COUNT_W-1:0]   cnt_sat;

  always_comb begin
    len_sat   = (req.pattern_length > lspe_pkg::LEN_MAX) ? lspe_pkg::LEN_MAX
                                                         : req.pattern_length;
    scale_eff = (req.scale_factor == '0) ? lspe_pkg::SCALE_W'(1) : req.scale_factor;
    slen_calc = lspe_pkg::SLEN_W'(len_sat) * lspe_pkg::SLEN_W'(scale_eff);
    // least s with 32*s % slen == 0 is odd(slen) << max(0, tz - 5)
    extra_shift = (tz > lspe_pkg::WORD_SHIFT) ? 3'(tz - lspe_pkg::WORD_SHIFT) : 3'd0;
    cnt_raw     = 20'(odd) << extra_shift;
    cnt_sat     = (cnt_raw > 20'(lspe_pkg::COUNT_CAP)) ? lspe_pkg::COUNT_CAP
                                                       : cnt_raw[lspe_pkg::COUNT_W-1:0];
  end

  assign req.ready = (state == F_IDLE);
  assign job_valid = (state == F_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (req.valid) begin
            job.pattern_bits <= req.pattern_bits;
            job.len          <= len_sat;
            job.scale        <= scale_eff;
            odd              <= slen_calc;
            tz               <= '0;
            if (len_sat == '0) begin
              job.solid <= 1'b1;
              job.slen  <= '0;
              job.count <= lspe_pkg::COUNT_W'(1);
              state     <= F_PUSH;
            end else begin
              job.solid <= 1'b0;
              job.slen  <= slen_calc;
              state     <= F_SEARCH;
            end
          end
        end
        F_SEARCH: begin
          if (!odd[0]) begin
            odd <= odd >> 1;
            tz  <= tz + lspe_pkg::TZ_W'(1);
          end else begin
            job.count <= cnt_sat;
            state     <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (job_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/lspe_queue.sv */
// Short job queue between front and back so each side stalls on its own.
// Uses lspe_pkg (lspe_job_t, QUEUE_DEPTH).
module lspe_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  lspe_pkg::lspe_job_t push_job,
  output logic                pop_valid,
  input  logic                pop_ready,
  output lspe_pkg::lspe_job_t pop_job
);

  lspe_pkg::lspe_job_t           entries [lspe_pkg::QUEUE_DEPTH];
  logic [lspe_pkg::QPTR_W-1:0]   wr_ptr;
  logic [lspe_pkg::QPTR_W-1:0]   rd_ptr;
  logic [lspe_pkg::QPTR_W:0]     fill;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = (fill != (lspe_pkg::QPTR_W+1)'(lspe_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == lspe_pkg::QPTR_W'(lspe_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == lspe_pkg::QPTR_W'(lspe_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/lspe_back.sv */
// Back end: bit-serial expansion of one job into pattern words, one sub-pixel
// per cycle unless the output register is full at a word end. Uses lspe_pkg, lspe_word_if.
module lspe_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  lspe_pkg::lspe_job_t job,
  lspe_word_if.source         rsp
);

  typedef enum logic {B_IDLE, B_RUN} state_t;

  state_t                          state;
  lspe_pkg::lspe_job_t             cur;
  logic [lspe_pkg::POS_W-1:0]      pos;
  logic [lspe_pkg::SCALE_W-1:0]    sub;
  logic [lspe_pkg::POS_W-1:0]      bit_idx;
  logic [lspe_pkg::IDX_W-1:0]      idx;
  logic [lspe_pkg::BITS_W-1:0]     acc;

  logic                            out_valid;
  logic [lspe_pkg::BITS_W-1:0]     out_word;
  logic [lspe_pkg::IDX_W-1:0]      out_idx;
  logic [lspe_pkg::COUNT_W-1:0]    out_count;
  logic [lspe_pkg::SLEN_W-1:0]     out_slen;
  logic                            out_last;

  logic [lspe_pkg::POS_W:0]        pos_inc;
  logic [lspe_pkg::POS_W-1:0]      nxt_pos;
  logic                            px;
  logic                            word_end;
  logic                            is_last;
  logic                            step;
  logic                            sub_wrap;

  always_comb begin
    pos_inc  = {1'b0, pos} + 1'b1;
    nxt_pos  = (pos_inc == cur.len) ? '0 : pos_inc[lspe_pkg::POS_W-1:0];
    // set pixel stays set into a set neighbor, else only its first sub-pixel
    px       = cur.solid || (cur.pattern_bits[pos] &&
                             (cur.pattern_bits[nxt_pos] || (sub == '0)));
    word_end = (bit_idx == lspe_pkg::POS_W'(lspe_pkg::WORD_BITS - 1));
    is_last  = ({1'b0, idx} + 1'b1) == cur.count;
    step     = (state == B_RUN) && !(word_end && out_valid && !rsp.ready);
    sub_wrap = ({1'b0, sub} + 1'b1) == {1'b0, cur.scale};
  end

  assign job_ready         = (state == B_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.pattern_word  = out_word;
  assign rsp.word_index    = out_idx;
  assign rsp.word_count    = out_count;
  assign rsp.scaled_length = out_slen;
  assign rsp.last_word     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a finished word refills the register, else a taken word empties it
      if (step && word_end) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            cur     <= job;
            pos     <= '0;
            sub     <= '0;
            bit_idx <= '0;
            idx     <= '0;
            state   <= B_RUN;
          end
        end
        B_RUN: begin
          if (step) begin
            acc[bit_idx] <= px;
            bit_idx      <= bit_idx + 1'b1;
            if (sub_wrap) begin
              sub <= '0;
              pos <= nxt_pos;
            end else begin
              sub <= sub + 1'b1;
            end
            if (word_end) begin
              out_word  <= {px, acc[lspe_pkg::BITS_W-2:0]};
              out_idx   <= idx;
              out_count <= cur.count;
              out_slen  <= cur.slen;
              out_last  <= is_last;
              idx       <= idx + 1'b1;
              if (is_last) begin
                state <= B_IDLE;
              end
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/line_stipple_pattern_expander_core.sv */
// Line stipple pattern expander, top level. Instantiates lspe_front,
// lspe_queue and lspe_back; uses lspe_pkg, lspe_req_if and lspe_word_if.
//
// Each request transaction (pattern bits, length, scale) yields a run of
// 32-bit expanded pattern words, one result transaction per word, ending with
// last_word set. Length is clamped to 32, scale 0 acts as 1, and length 0
// gives a single all-ones word with scaled_length 0. The word count is the
// smallest s with 32*s a multiple of length*scale, capped at 32 words.
// Flow: the front end accepts a request, strips one trailing zero of the
// scaled length per search step (at most 12), settles the word count and
// hands the job over (a solid pattern goes straight to the hand-over); the
// hand-over waits while the job queue is full. The back end loads a job and
// then builds its words bit-serially, one sub-pixel per cycle. The two-entry
// job queue lets the front end classify the next requests while the back
// end is still expanding, and the output register lets expansion run on
// while the last finished word waits for the sink; expansion pauses only when
// a new word is complete and the previous one has still not been taken.
module line_stipple_pattern_expander_core (
  input  logic        clk,
  input  logic        rst,
  lspe_req_if.sink    req,
  lspe_word_if.source rsp
);

  // front -> queue
  logic                f2q_valid;
  logic                f2q_ready;
  lspe_pkg::lspe_job_t f2q_job;
  // queue -> back
  logic                q2b_valid;
  logic                q2b_ready;
  lspe_pkg::lspe_job_t q2b_job;

  lspe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .job_valid (f2q_valid),
    .job_ready (f2q_ready),
    .job       (f2q_job)
  );

  lspe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f2q_valid),
    .push_ready (f2q_ready),
    .push_job   (f2q_job),
    .pop_valid  (q2b_valid),
    .pop_ready  (q2b_ready),
    .pop_job    (q2b_job)
  );

  lspe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q2b_valid),
    .job_ready (q2b_ready),
    .job       (q2b_job),
    .rsp       (rsp)
  );

  // word count out of the search always lands in 1..COUNT_CAP
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.word_count != '0) && (rsp.word_count <= lspe_pkg::COUNT_CAP))
    else $error("word_count out of range");

  // last flag marks exactly the final index of the run
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.last_word ==
                   (({1'b0, rsp.word_index} + 1'b1) == rsp.word_count)))
    else $error("last_word disagrees with word_index/word_count");

  // a solid request is a single all-ones word
  a_solid_word: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.scaled_length == '0)) |->
      (rsp.pattern_word == lspe_pkg::SOLID_WORD) && (rsp.word_count == 7'd1))
    else $error("solid pattern word malformed");

  // classified job for a nonzero length carries a nonzero scaled length
  a_job_slen: assert property (@(posedge clk) disable iff (rst)
    (f2q_valid && !f2q_job.solid) |-> (f2q_job.slen != '0))
    else $error("non-solid job with zero scaled length");

endmodule

/* verif/line_stipple_pattern_expander_core_test.sv */
// Self-checking testbench for line_stipple_pattern_expander_core.
// Depends on lspe_pkg, lspe_req_if and lspe_word_if from rtl/core; drives
// directed and random stipple requests and checks every expanded word.
module line_stipple_pattern_expander_core_test;

  // one expanded word as seen on the result channel
  typedef struct packed {
    logic [lspe_pkg::BITS_W-1:0]  word;
    logic [lspe_pkg::IDX_W-1:0]   index;
    logic [lspe_pkg::COUNT_W-1:0] count;
    logic [lspe_pkg::SLEN_W-1:0]  slen;
    logic                         last;
  } pattern_word_t;

  // directed request; hand-typed rows are always single-word requests
  typedef struct packed {
    logic [lspe_pkg::BITS_W-1:0]  bits;
    logic [lspe_pkg::LEN_W-1:0]   len;
    logic [lspe_pkg::SCALE_W-1:0] scale;
    logic                         typed;
    logic [lspe_pkg::BITS_W-1:0]  word;
    logic [lspe_pkg::COUNT_W-1:0] count;
    logic [lspe_pkg::SLEN_W-1:0]  slen;
  } stipple_row_t;

  localparam int NUM_DIRECTED  = 21;
  localparam int NUM_RANDOM    = 160;
  localparam int IDLE_PERCENT  = 37;
  localparam int REPORT_LIMIT  = 10;
  // drain margin, sized above one back-end request at the word cap
  localparam int DRAIN_CYCLES  = 1200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lspe_req_if  req ();
  lspe_word_if rsp ();

  line_stipple_pattern_expander_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #2 clk = ~clk;

  pattern_word_t pending_words[$];  // expected words, oldest first
  int            error_count = 0;
  bit            no_idle     = 1'b0; // set for a stretch of random requests

  // Directed rows. Typed rows:
  //   solid pattern (length 0), any scale -> one all-ones word, slen 0
  //   length 32 unscaled -> the pattern bits verbatim, one word
  //   long length saturates to 32, zero scale acts as 1
  //   single pixel, bits above the length ignored
  // The rest cover set/clear runs under scaling, odd lengths (many words),
  // the word cap and the maximum scaled length.
  stipple_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'h0000_0000, 6'd0,  8'd0,   1'b1, 32'hFFFF_FFFF, 7'd1, 13'd0},
    '{32'h1234_5678, 6'd0,  8'd255, 1'b1, 32'hFFFF_FFFF, 7'd1, 13'd0},
    '{32'hA5A5_1234, 6'd32, 8'd1,   1'b1, 32'hA5A5_1234, 7'd1, 13'd32},
    '{32'hFFFF_FFFF, 6'd63, 8'd0,   1'b1, 32'hFFFF_FFFF, 7'd1, 13'd32},
    '{32'h0000_0000, 6'd33, 8'd1,   1'b1, 32'h0000_0000, 7'd1, 13'd32},
    '{32'h0000_0001, 6'd1,  8'd1,   1'b1, 32'hFFFF_FFFF, 7'd1, 13'd1},
    '{32'hFFFF_FFFE, 6'd1,  8'd0,   1'b1, 32'h0000_0000, 7'd1, 13'd1},
    '{32'h0000_0005, 6'd3,  8'd1,   1'b0, '0, '0, '0},
    '{32'h0000_0013, 6'd5,  8'd255, 1'b0, '0, '0, '0},
    '{32'hDEAD_BEEF, 6'd32, 8'd255, 1'b0, '0, '0, '0},
    '{32'h0000_0001, 6'd2,  8'd2,   1'b0, '0, '0, '0},
    '{32'h0000_0003, 6'd2,  8'd3,   1'b0, '0, '0, '0},
    '{32'h0000_000B, 6'd4,  8'd8,   1'b0, '0, '0, '0},
    '{32'h7FFF_FFFF, 6'd31, 8'd1,   1'b0, '0, '0, '0},
    '{32'h8000_0001, 6'd32, 8'd2,   1'b0, '0, '0, '0},
    '{32'hC3C3_3C3C, 6'd16, 8'd16,  1'b0, '0, '0, '0},
    '{32'h0000_0055, 6'd7,  8'd0,   1'b0, '0, '0, '0},
    '{32'h0000_0001, 6'd1,  8'd255, 1'b0, '0, '0, '0},
    '{32'hFFFF_FFFF, 6'd63, 8'd255, 1'b0, '0, '0, '0},
    '{32'h0000_002D, 6'd6,  8'd128, 1'b0, '0, '0, '0},
    '{32'h0F0F_0F0F, 6'd24, 8'd3,   1'b0, '0, '0, '0}
  };

  // Expand one request into the words it should produce and queue them.
  // A set pixel stays set for all its sub-pixels only if the next pixel
  // (cyclically) is set too; otherwise only its first sub-pixel is drawn.
  function automatic void expand_stipple(input logic [lspe_pkg::BITS_W-1:0] bits,
                                         input logic [lspe_pkg::LEN_W-1:0] len,
                                         input logic [lspe_pkg::SCALE_W-1:0] scale);
    int unsigned   eff_len;
    int unsigned   reps;
    int unsigned   slen;
    int unsigned   count;
    int unsigned   pos;
    int unsigned   sub;
    int unsigned   nxt;
    pattern_word_t w;

    eff_len = (len > lspe_pkg::WORD_BITS) ? lspe_pkg::WORD_BITS : len;
    reps    = (scale == 0) ? 1 : scale;
    if (eff_len == 0) begin
      w = '{lspe_pkg::SOLID_WORD, '0, lspe_pkg::COUNT_W'(1), '0, 1'b1};
      pending_words = {pending_words, w};
      return;
    end
    slen  = eff_len * reps;
    count = 1;
    while (((count * lspe_pkg::WORD_BITS) % slen) != 0 && count < lspe_pkg::WORD_LIMIT)
      count++;
    pos = 0;
    sub = 0;
    for (int unsigned i = 0; i < count; i++) begin
      w.word = '0;
      for (int m = 0; m < lspe_pkg::WORD_BITS; m++) begin
        nxt = (pos + 1 == eff_len) ? 0 : pos + 1;
        if (bits[pos] && (bits[nxt] || sub == 0))
          w.word[m] = 1'b1;
        sub++;
        if (sub == reps) begin
          sub = 0;
          pos = nxt;
        end
      end
      w.index = lspe_pkg::IDX_W'(i);
      w.count = lspe_pkg::COUNT_W'(count);
      w.slen  = lspe_pkg::SLEN_W'(slen);
      w.last  = (i + 1 == count);
      pending_words = {pending_words, w};
    end
  endfunction

  // Drive one request transaction. Entered and left at a falling edge;
  // valid is left high so a back-to-back request keeps it up.
  task automatic send_request(input logic [lspe_pkg::BITS_W-1:0] bits,
                              input logic [lspe_pkg::LEN_W-1:0] len,
                              input logic [lspe_pkg::SCALE_W-1:0] scale,
                              input logic typed,
                              input pattern_word_t typed_word);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid          <= 1'b1;
    req.pattern_bits   <= bits;
    req.pattern_length <= len;
    req.scale_factor   <= scale;
    do
      @(posedge clk);
    while (!req.ready);
    // accepted on this edge; its words cannot appear before a later edge
    if (typed)
      pending_words = {pending_words, typed_word};
    else
      expand_stipple(bits, len, scale);
    @(negedge clk);
  endtask

  // Result sink: random back-pressure, none during the steady stretch.
  always @(negedge clk) begin
    if (rst)
      rsp.ready <= 1'b0;
    else
      rsp.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Check each result transaction against the oldest expected word.
  always @(posedge clk) begin : word_check
    pattern_word_t want;
    pattern_word_t got;

    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.pattern_word, rsp.word_index, rsp.word_count,
              rsp.scaled_length, rsp.last_word};
      if (pending_words.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected word: word=%h idx=%0d count=%0d slen=%0d last=%0b",
                   got.word, got.index, got.count, got.slen, got.last);
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display({"mismatch: exp word=%h idx=%0d count=%0d slen=%0d last=%0b",
                      " | got word=%h idx=%0d count=%0d slen=%0d last=%0b"},
                     want.word, want.index, want.count, want.slen, want.last,
                     got.word, got.index, got.count, got.slen, got.last);
        end
      end
    end
  end

  // Stimulus: reset, directed table, random requests, drain, verdict.
  initial begin : stimulus
    logic [lspe_pkg::LEN_W-1:0]   len;
    logic [lspe_pkg::SCALE_W-1:0] scale;
    pattern_word_t                typed_word;

    req.valid          = 1'b0;
    req.pattern_bits   = '0;
    req.pattern_length = '0;
    req.scale_factor   = '0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      typed_word = '{directed_rows[i].word, '0, directed_rows[i].count,
                     directed_rows[i].slen, 1'b1};
      send_request(directed_rows[i].bits, directed_rows[i].len,
                   directed_rows[i].scale, directed_rows[i].typed, typed_word);
    end

    // Random part: mostly small scales (quick, few words), some powers of
    // two, some fully random scales that tend to hit the word cap.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      no_idle = (n >= 60 && n < 100);
      len = lspe_pkg::LEN_W'($urandom_range(0, 63));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: scale = lspe_pkg::SCALE_W'($urandom_range(0, 4));
        6, 7:             scale = lspe_pkg::SCALE_W'(1 << $urandom_range(0, 7));
        default:          scale = lspe_pkg::SCALE_W'($urandom_range(0, 255));
      endcase
      send_request($urandom(), len, scale, 1'b0, '0);
    end
    no_idle   = 1'b0;
    req.valid <= 1'b0;

    while (pending_words.size() != 0)
      @(posedge clk);
    // let any stray word out before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_words.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Hard stop: well beyond the slowest legal run (about 180 requests at
  // the word cap, each word stalled by back-pressure).
  initial begin
    #10000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
